// ===== sv/bpc_pkg.sv =====
// Shared constants and types for the bipartite check block.
package bpc_pkg;

    // Largest graph the block holds
    localparam int MAX_VERTICES = 64;

    // Fixed field widths of the ports
    localparam int FIELD_W = 6;
    localparam int CFG_W   = 7;

    // Widths that follow from the graph size
    localparam int VERT_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    // Item function codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // Vertex color codes
    localparam logic [1:0] COLOR_NONE = 2'd0;
    localparam logic [1:0] COLOR_A    = 2'd1;
    localparam logic [1:0] COLOR_B    = 2'd2;

    // Reset value of the vertex count register
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(MAX_VERTICES);

    // One walk stack entry: vertex and next neighbor index to examine
    typedef struct packed {
        logic [VERT_W-1:0] vert;
        logic [CNT_W-1:0]  idx;
    } stack_entry_t;

endpackage

// ===== sv/bpc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bipartite_check.sv =====
// Top level of the bipartite check: edge loading and two-coloring walk.
// Edges: one with an endpoint out of range is dropped from idle, a self-loop edge writes its
//   one row (S_EA), any other edge does a read-modify-write of both rows through one RAM port.
// Evaluate is run by the walk sequencer: one neighbor bit per cycle while no color read or
//   row reload is pending.
// Throughput: one item in flight at a time; the next item is taken once the last one is done.
// Reset: rst_n is asynchronous; valid bits mark all rows and colors empty, no clearing pass.
module bipartite_check (
    input  logic                         clk,
    input  logic                         rst_n,
    // input item channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [bpc_pkg::FIELD_W-1:0]  vertex_a,
    input  logic [bpc_pkg::FIELD_W-1:0]  vertex_b,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         is_bipartite,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bpc_pkg::CFG_W-1:0]    vertex_count
);

    localparam int VW = bpc_pkg::VERT_W;
    localparam int CW = bpc_pkg::CNT_W;
    localparam int NV = bpc_pkg::MAX_VERTICES;
    localparam int SW = $bits(bpc_pkg::stack_entry_t);

    // Sequencer state codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EA     = 4'd1;   // row a back: write it, read row b unless a self-loop
    localparam logic [3:0] S_EB     = 4'd2;   // row b back: write it
    localparam logic [3:0] S_SCAN   = 4'd3;   // pick next start vertex
    localparam logic [3:0] S_SCAN_W = 4'd4;   // start vertex color back
    localparam logic [3:0] S_ROW    = 4'd5;   // read adjacency row of stack top
    localparam logic [3:0] S_ROW_W  = 4'd6;   // row back into row register
    localparam logic [3:0] S_STEP   = 4'd7;   // examine one neighbor bit
    localparam logic [3:0] S_COL_W  = 4'd8;   // neighbor color back
    localparam logic [3:0] S_POP_W  = 4'd9;   // entry below top back from stack
    localparam logic [3:0] S_DONE   = 4'd10;  // hand result to output register

    logic [3:0]    state_reg, state_next;
    logic [VW-1:0] a_reg, a_next;
    logic [VW-1:0] b_reg, b_next;
    logic [CW-1:0] s_reg, s_next;
    logic [VW-1:0] top_v_reg, top_v_next;
    logic [CW-1:0] top_j_reg, top_j_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [VW-1:0] j_reg, j_next;
    logic [NV-1:0] row_reg, row_next;
    logic          result_reg, result_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_bit_reg, out_bit_next;
    logic [NV-1:0] adj_valid_reg, adj_valid_next;
    logic [NV-1:0] color_valid_reg, color_valid_next;
    logic          adj_rv_reg;
    logic          color_rv_reg;
    logic [bpc_pkg::CFG_W-1:0] vertex_count_reg;

    // RAM ports
    logic          adj_we;
    logic [VW-1:0] adj_waddr, adj_raddr;
    logic [NV-1:0] adj_wdata, adj_rdata;
    logic          color_we;
    logic [VW-1:0] color_waddr, color_raddr;
    logic [1:0]    color_wdata, color_rdata;
    logic          stack_we;
    logic [VW-1:0] stack_waddr, stack_raddr;
    logic [SW-1:0] stack_wdata, stack_rdata;

    logic [CW-1:0] n_act;
    logic [NV-1:0] adj_row;
    logic [1:0]    color_rd;
    logic [1:0]    top_color;
    logic [1:0]    other_color;
    logic [CW-1:0] depth_m1;
    logic [CW-1:0] depth_m2;
    logic          slot_free;
    logic          a_in_range;
    logic          b_in_range;
    bpc_pkg::stack_entry_t push_entry;
    bpc_pkg::stack_entry_t pop_entry;

    // Adjacency rows, one per vertex
    bpc_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // Vertex colors
    bpc_ram #(.WIDTH(2), .DEPTH(NV)) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .waddr (color_waddr),
        .wdata (color_wdata),
        .raddr (color_raddr),
        .rdata (color_rdata)
    );

    // Walk stack below the cached top entry
    bpc_ram #(.WIDTH(SW), .DEPTH(NV)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Active vertex count, saturated to the matrix size
    assign n_act = (vertex_count_reg > bpc_pkg::CFG_W'(NV)) ? CW'(NV)
                                                          : vertex_count_reg[CW-1:0];

    assign a_in_range = {1'b0, vertex_a} < n_act;
    assign b_in_range = {1'b0, vertex_b} < n_act;

    // A row or color never written since the last clear reads as zero
    assign adj_row  = adj_rv_reg ? adj_rdata : '0;
    assign color_rd = color_rv_reg ? color_rdata : bpc_pkg::COLOR_NONE;

    // Colors alternate with stack level: the bottom entry is always the first color
    assign top_color   = depth_reg[0] ? bpc_pkg::COLOR_A : bpc_pkg::COLOR_B;
    assign other_color = depth_reg[0] ? bpc_pkg::COLOR_B : bpc_pkg::COLOR_A;

    assign depth_m1 = depth_reg - CW'(1);
    assign depth_m2 = depth_reg - CW'(2);

    assign push_entry.vert = top_v_reg;
    assign push_entry.idx  = top_j_reg;
    assign pop_entry       = bpc_pkg::stack_entry_t'(stack_rdata);

    // Output register is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign is_bipartite = out_bit_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        s_next           = s_reg;
        top_v_next       = top_v_reg;
        top_j_next       = top_j_reg;
        depth_next       = depth_reg;
        j_next           = j_reg;
        row_next         = row_reg;
        result_next      = result_reg;
        adj_valid_next   = adj_valid_reg;
        color_valid_next = color_valid_reg;
        out_bit_next     = out_bit_reg;
        out_valid_next   = out_valid_reg;

        adj_we      = 1'b0;
        adj_waddr   = a_reg;
        adj_wdata   = adj_row;
        adj_raddr   = a_reg;
        color_we    = 1'b0;
        color_waddr = j_reg;
        color_wdata = bpc_pkg::COLOR_NONE;
        color_raddr = j_reg;
        stack_we    = 1'b0;
        stack_waddr = depth_m1[VW-1:0];
        stack_wdata = push_entry;
        stack_raddr = depth_m2[VW-1:0];

        // Drop the result once the downstream side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == bpc_pkg::FUNC_EVAL)
                    begin
                        s_next     = '0;
                        depth_next = '0;
                        state_next = S_SCAN;
                    end
                    else if (a_in_range && b_in_range)
                    begin
                        a_next     = vertex_a[VW-1:0];
                        b_next     = vertex_b[VW-1:0];
                        adj_raddr  = vertex_a[VW-1:0];
                        state_next = S_EA;
                    end
                end
            end

            S_EA:
            begin
                adj_we    = 1'b1;
                adj_waddr = a_reg;
                adj_wdata = adj_row | (NV'(1) << b_reg);
                adj_valid_next[a_reg] = 1'b1;
                if (a_reg == b_reg)
                begin
                    // Self-loop: the one row write already holds the diagonal bit
                    state_next = S_IDLE;
                end
                else
                begin
                    adj_raddr  = b_reg;
                    state_next = S_EB;
                end
            end

            S_EB:
            begin
                adj_we    = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = adj_row | (NV'(1) << a_reg);
                adj_valid_next[b_reg] = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                if (s_reg >= n_act)
                begin
                    result_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    color_raddr = s_reg[VW-1:0];
                    state_next  = S_SCAN_W;
                end
            end

            S_SCAN_W:
            begin
                if (color_rd != bpc_pkg::COLOR_NONE)
                begin
                    s_next     = s_reg + CW'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    // Start a new walk from this vertex
                    color_we    = 1'b1;
                    color_waddr = s_reg[VW-1:0];
                    color_wdata = bpc_pkg::COLOR_A;
                    color_valid_next[s_reg[VW-1:0]] = 1'b1;
                    top_v_next  = s_reg[VW-1:0];
                    top_j_next  = '0;
                    depth_next  = CW'(1);
                    state_next  = S_ROW;
                end
            end

            S_ROW:
            begin
                adj_raddr  = top_v_reg;
                state_next = S_ROW_W;
            end

            S_ROW_W:
            begin
                row_next   = adj_row;
                state_next = S_STEP;
            end

            S_STEP:
            begin
                if (top_j_reg >= n_act)
                begin
                    // Top vertex exhausted: pop it
                    depth_next = depth_m1;
                    if (depth_reg == CW'(1))
                    begin
                        s_next     = s_reg + CW'(1);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_POP_W;
                    end
                end
                else
                begin
                    top_j_next = top_j_reg + CW'(1);
                    if (row_reg[top_j_reg[VW-1:0]])
                    begin
                        j_next      = top_j_reg[VW-1:0];
                        color_raddr = top_j_reg[VW-1:0];
                        state_next  = S_COL_W;
                    end
                end
            end

            S_COL_W:
            begin
                if (color_rd == top_color)
                begin
                    result_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (color_rd == bpc_pkg::COLOR_NONE)
                begin
                    color_we    = 1'b1;
                    color_waddr = j_reg;
                    color_wdata = other_color;
                    color_valid_next[j_reg] = 1'b1;
                    if (depth_reg < CW'(NV))
                    begin
                        // Push: spill the current top, neighbor becomes the top
                        stack_we    = 1'b1;
                        stack_waddr = depth_m1[VW-1:0];
                        stack_wdata = push_entry;
                        top_v_next  = j_reg;
                        top_j_next  = '0;
                        depth_next  = depth_reg + CW'(1);
                        state_next  = S_ROW;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
                else
                begin
                    state_next = S_STEP;
                end
            end

            S_POP_W:
            begin
                top_v_next = pop_entry.vert;
                top_j_next = pop_entry.idx;
                state_next = S_ROW;
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    // Emit the result and clear the graph for the next one
                    out_valid_next   = 1'b1;
                    out_bit_next     = result_reg;
                    adj_valid_next   = '0;
                    color_valid_next = '0;
                    depth_next       = '0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            depth_reg        <= '0;
            out_valid_reg    <= 1'b0;
            adj_valid_reg    <= '0;
            color_valid_reg  <= '0;
            adj_rv_reg       <= 1'b0;
            color_rv_reg     <= 1'b0;
            vertex_count_reg <= bpc_pkg::VERTEX_COUNT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            depth_reg       <= depth_next;
            out_valid_reg   <= out_valid_next;
            adj_valid_reg   <= adj_valid_next;
            color_valid_reg <= color_valid_next;
            // Track validity of the row and color being read this cycle
            adj_rv_reg      <= adj_valid_reg[adj_raddr];
            color_rv_reg    <= color_valid_reg[color_raddr];
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= vertex_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        s_reg       <= s_next;
        top_v_reg   <= top_v_next;
        top_j_reg   <= top_j_next;
        j_reg       <= j_next;
        row_reg     <= row_next;
        result_reg  <= result_next;
        out_bit_reg <= out_bit_next;
    end

    // The stack never grows past the vertex count of the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CW'(NV))
        else $error("walk stack depth overflow");

    // Neighbor scan always has a top entry on the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP || state_reg == S_COL_W) |-> (depth_reg != '0))
        else $error("neighbor scan with empty stack");

    // Only rows of active vertices are ever written
    assert property (@(posedge clk) disable iff (!rst_n)
        adj_we |-> ({1'b0, adj_waddr} < n_act))
        else $error("adjacency write beyond active vertex count");

    // Emitting a result clears every row and color and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=>
            (adj_valid_reg == '0 && color_valid_reg == '0 && state_reg == S_IDLE
             && out_valid_reg))
        else $error("graph not cleared after result");

    // The top vertex of an active walk is already colored
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> color_valid_reg[top_v_reg])
        else $error("walk top vertex uncolored");

endmodule

// ===== sim/bipartite_check_checker.sv =====
// Checker for the bipartite check block: tracks the loaded graph and scores every verdict.
module bipartite_check_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        func,
    input  logic [bpc_pkg::FIELD_W-1:0] vertex_a,
    input  logic [bpc_pkg::FIELD_W-1:0] vertex_b,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        is_bipartite,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [bpc_pkg::CFG_W-1:0]   vertex_count,
    output int                          errors,
    output int                          outstanding,
    output int                          graphs_checked,
    output int                          bipartite_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [bpc_pkg::MAX_VERTICES-1:0] adj_rows [bpc_pkg::MAX_VERTICES];
    logic [1:0]                       paint [bpc_pkg::MAX_VERTICES];
    logic [bpc_pkg::CFG_W-1:0]        count_reg;
    bit                               verdict_q [$];
    bit                               want;
    int unsigned                      live_n;

    initial
    begin
        errors         = 0;
        outstanding    = 0;
        graphs_checked = 0;
        bipartite_seen = 0;
    end

    function automatic int unsigned active_vertices();
        return (count_reg > bpc_pkg::MAX_VERTICES) ? bpc_pkg::MAX_VERTICES : count_reg;
    endfunction

    function automatic void wipe_graph();
        foreach (adj_rows[v])
        begin
            adj_rows[v] = '0;
            paint[v]    = bpc_pkg::COLOR_NONE;
        end
    endfunction

    // Depth-first two-coloring with an explicit stack; stop at the first clash.
    function automatic bit two_colorable(int unsigned n);
        int unsigned walk_vert [bpc_pkg::MAX_VERTICES];
        int unsigned walk_next [bpc_pkg::MAX_VERTICES];
        int unsigned depth;
        int unsigned s;
        int unsigned v;
        int unsigned j;
        for (s = 0; s < n; s++)
        begin
            if (paint[s] != bpc_pkg::COLOR_NONE)
                continue;
            paint[s]     = bpc_pkg::COLOR_A;
            walk_vert[0] = s;
            walk_next[0] = 0;
            depth        = 1;
            while (depth > 0)
            begin
                v = walk_vert[depth-1];
                j = walk_next[depth-1];
                if (j >= n)
                begin
                    depth--;
                    continue;
                end
                walk_next[depth-1] = j + 1;
                if (!adj_rows[v][j])
                    continue;
                if (paint[j] == paint[v])
                    return 1'b0;
                if (paint[j] == bpc_pkg::COLOR_NONE)
                begin
                    paint[j]         = (paint[v] == bpc_pkg::COLOR_A) ? bpc_pkg::COLOR_B
                                                                       : bpc_pkg::COLOR_A;
                    walk_vert[depth] = j;
                    walk_next[depth] = 0;
                    depth++;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0d ns: MISMATCH %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_graph();
            count_reg = bpc_pkg::VERTEX_COUNT_RESET;
            verdict_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg = vertex_count;

            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result with no evaluate waiting");
                else
                begin
                    want = verdict_q.pop_front();
                    graphs_checked++;
                    if (want)
                        bipartite_seen++;
                    if (is_bipartite !== want)
                        report_mismatch($sformatf("is_bipartite got %b, want %b",
                                                  is_bipartite, want));
                end
            end

            if (in_valid && !in_stall)
            begin
                live_n = active_vertices();
                if (func == bpc_pkg::FUNC_ADD)
                begin
                    if (vertex_a < live_n && vertex_b < live_n)
                    begin
                        adj_rows[vertex_a][vertex_b] = 1'b1;
                        adj_rows[vertex_b][vertex_a] = 1'b1;
                    end
                end
                else
                begin
                    verdict_q.push_back(two_colorable(live_n));
                    wipe_graph();
                end
            end

            outstanding <= verdict_q.size();
        end
    end

endmodule

// ===== sim/bipartite_check_tb.sv =====
// Testbench top for the bipartite check block: stimulus, output back-pressure and verdict.
module bipartite_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS     = 1250;
    localparam int LONG_HOLD_CYCLES = 400;
    // An edge occupies the block for a while with no result to show for it.
    localparam int SETTLE_CYCLES    = 8;
    localparam int END_CYCLES       = 20;

    typedef enum int {
        GRAPH_SPLIT,
        GRAPH_RANDOM,
        GRAPH_ODD_CYCLE,
        GRAPH_PATH,
        GRAPH_SELF_LOOP
    } graph_kind_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic                        func         = bpc_pkg::FUNC_ADD;
    logic [bpc_pkg::FIELD_W-1:0] vertex_a     = '0;
    logic [bpc_pkg::FIELD_W-1:0] vertex_b     = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic                        is_bipartite;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [bpc_pkg::CFG_W-1:0]   vertex_count = bpc_pkg::VERTEX_COUNT_RESET;

    int errors;
    int outstanding;
    int graphs_checked;
    int bipartite_seen;

    // Sender bookkeeping: offering tracks in_valid so it gets one assignment per step.
    bit          offering     = 1'b0;
    bit          burst        = 1'b0;
    int          useful_items = 0;
    int unsigned live_n       = bpc_pkg::MAX_VERTICES;

    // Receiver bookkeeping
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          stall_run     = 0;
    int unsigned stall_roll;

    always #1 clk = ~clk;

    bipartite_check i_dut (.*);

    bipartite_check_checker i_checker (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Offer one transaction, hold it until taken, then maybe drop valid for a while.
    task automatic send_item(logic f, logic [bpc_pkg::FIELD_W-1:0] a,
                             logic [bpc_pkg::FIELD_W-1:0] b);
        int unsigned gap;
        if (!offering)
            in_valid <= 1'b1;
        offering = 1'b1;
        func     <= f;
        vertex_a <= a;
        vertex_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Add an edge with its endpoints in random order.
    task automatic send_edge(int unsigned u, int unsigned w);
        if (u < live_n && w < live_n)
            useful_items++;
        if ($urandom_range(0, 1))
            send_item(bpc_pkg::FUNC_ADD, bpc_pkg::FIELD_W'(u), bpc_pkg::FIELD_W'(w));
        else
            send_item(bpc_pkg::FUNC_ADD, bpc_pkg::FIELD_W'(w), bpc_pkg::FIELD_W'(u));
    endtask

    // Endpoint fields carry junk on evaluate; the block must ignore them.
    task automatic evaluate();
        useful_items++;
        send_item(bpc_pkg::FUNC_EVAL, bpc_pkg::FIELD_W'($urandom),
                  bpc_pkg::FIELD_W'($urandom));
    endtask

    // Stop offering, wait out every pending verdict, then let a last edge finish.
    task automatic quiesce();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [bpc_pkg::CFG_W-1:0] value);
        quiesce();
        cfg_valid    <= 1'b1;
        vertex_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        live_n = (value > bpc_pkg::MAX_VERTICES) ? bpc_pkg::MAX_VERTICES : value;
    endtask

    // Result side back-pressure: random stall and free runs, calm stretches, and a
    // long hold-off whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_run > 0)
                stall_run--;
            else
            begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 4)
                begin
                    out_stall <= 1'b0;
                    stall_run = $urandom_range(150, 400);
                end
                else if (stall_roll < 40)
                begin
                    out_stall <= 1'b1;
                    stall_run = pick_gap();
                end
                else
                begin
                    out_stall <= 1'b0;
                    stall_run = $urandom_range(0, 5);
                end
            end
        end
    end

    initial
    begin
        int unsigned               order [bpc_pkg::MAX_VERTICES];
        bit                        side [bpc_pkg::MAX_VERTICES];
        int unsigned               edges;
        int unsigned               span;
        int unsigned               roll;
        int unsigned               k;
        int unsigned               u;
        int unsigned               w;
        int unsigned               tmp;
        int                        graph_no;
        bit                        pressing;
        graph_kind_t               kind;
        logic [bpc_pkg::CFG_W-1:0] new_count;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // Empty graph at the reset count: nothing can clash.
        evaluate();
        // Triangle through the highest and lowest vertex: odd cycle fails.
        send_edge(0, 63);
        send_edge(63, 62);
        send_edge(62, 0);
        evaluate();
        // Square: even cycle colors cleanly.
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 3);
        send_edge(3, 0);
        evaluate();
        // Three vertices: edges touching vertex 3 or above drop out.
        write_count(3);
        send_edge(0, 5);
        send_edge(63, 1);
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 3);
        evaluate();
        // No active vertex: even a self-loop is dropped and the answer is yes.
        write_count(0);
        send_edge(0, 0);
        evaluate();
        // Largest register value saturates to the full graph.
        write_count(bpc_pkg::CFG_W'((1 << bpc_pkg::CFG_W) - 1));
        send_edge(63, 0);
        send_edge(0, 1);
        evaluate();
        // Load at full size, then shrink: the triangle past the new count is not walked.
        send_edge(10, 11);
        send_edge(11, 12);
        send_edge(12, 10);
        send_edge(0, 1);
        write_count(5);
        evaluate();
        // Single vertex with a self-loop.
        write_count(1);
        send_edge(0, 0);
        evaluate();

        // ---------------- random graphs ----------------
        useful_items = 0;
        graph_no     = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            // Keep offering across a long result hold-off so the block backs up.
            pressing = (graph_no >= 15 && graph_no < 19) || (graph_no >= 70 && graph_no < 74);
            if (graph_no == 15 || graph_no == 70)
                hold_requests++;

            // Re-size the graph now and then. Keep most sizes small, since a full-size walk is long.
            roll = $urandom_range(0, 99);
            if (!pressing && roll < 50)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    new_count = '0;
                else if (roll < 8)
                    new_count = bpc_pkg::CFG_W'($urandom_range(bpc_pkg::MAX_VERTICES + 1,
                                                               (1 << bpc_pkg::CFG_W) - 1));
                else if (roll < 12)
                    new_count = bpc_pkg::CFG_W'(bpc_pkg::MAX_VERTICES);
                else if (roll < 18)
                    new_count = bpc_pkg::CFG_W'($urandom_range(41,
                                                               bpc_pkg::MAX_VERTICES - 1));
                else if (roll < 35)
                    new_count = bpc_pkg::CFG_W'($urandom_range(13, 40));
                else
                    new_count = bpc_pkg::CFG_W'($urandom_range(1, 12));
                write_count(new_count);
            end
            else if (!pressing && (roll < 56 || graph_no == 40))
                quiesce();

            burst = pressing || ($urandom_range(0, 4) == 0);

            roll = $urandom_range(0, 99);
            if (roll < 35)
                kind = GRAPH_SPLIT;
            else if (roll < 55)
                kind = GRAPH_RANDOM;
            else if (roll < 70)
                kind = GRAPH_ODD_CYCLE;
            else if (roll < 90)
                kind = GRAPH_PATH;
            else
                kind = GRAPH_SELF_LOOP;

            // Shuffle vertex labels and deal each vertex to one of two sides.
            for (k = 0; k < bpc_pkg::MAX_VERTICES; k++)
            begin
                order[k] = k;
                side[k]  = $urandom_range(0, 1);
            end
            for (k = live_n; k > 1; k--)
            begin
                u          = $urandom_range(0, k - 1);
                tmp        = order[k-1];
                order[k-1] = order[u];
                order[u]   = tmp;
            end
            edges = $urandom_range(0, (live_n < 8) ? 3 * live_n : 24);

            if (live_n != 0)
            begin
                case (kind)
                    GRAPH_RANDOM:
                        for (k = 0; k < edges; k++)
                            send_edge($urandom_range(0, live_n - 1),
                                      $urandom_range(0, live_n - 1));
                    GRAPH_PATH:
                    begin
                        // Long chain drives the walk stack deep; maybe close it into a ring.
                        for (k = 0; k + 1 < live_n; k++)
                            send_edge(order[k], order[k+1]);
                        if (live_n >= 3 && $urandom_range(0, 1))
                            send_edge(order[live_n-1], order[0]);
                    end
                    GRAPH_ODD_CYCLE:
                        if (live_n >= 3)
                        begin
                            span = (live_n < 15) ? live_n : 15;
                            span = 3 + 2 * $urandom_range(0, (span - 3) / 2);
                            for (k = 0; k < span; k++)
                                send_edge(order[k], order[(k + 1) % span]);
                        end
                    GRAPH_SELF_LOOP:
                        send_edge(order[0], order[0]);
                    default:
                        ;
                endcase
                // Cross-side edges keep the graph two-colorable on their own.
                if (kind != GRAPH_RANDOM && kind != GRAPH_PATH)
                    for (k = 0; k < edges; k++)
                    begin
                        u = $urandom_range(0, live_n - 1);
                        w = $urandom_range(0, live_n - 1);
                        if (side[u] != side[w])
                            send_edge(u, w);
                    end
            end

            // Stray edges anywhere in the field range, mostly past the count.
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3))
                    send_edge($urandom_range(0, bpc_pkg::MAX_VERTICES - 1),
                              $urandom_range(0, bpc_pkg::MAX_VERTICES - 1));

            evaluate();
            graph_no++;
        end

        // ---------------- wind down ----------------
        quiesce();
        repeat (END_CYCLES) @(posedge clk);
        $display("Run covered %0d graphs (%0d two-colorable) of every shape, vertex counts",
                 graphs_checked, bipartite_seen);
        $display("from 0 through saturation, random gaps on both channels and long hold-offs.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #200_000_000;
        $display("Timeout with %0d verdicts outstanding", outstanding);
        $display("Some tests failed");
        $finish;
    end

endmodule
